// ===== src/crfb_pkg.sv =====
// Package for the clipped raster fill and blit engine.
// Holds the framebuffer geometry, command and register codes, the shared
// structs and the pixel address function. No dependencies.
`default_nettype none

package crfb_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(FB_DEPTH);
   localparam int XW         = $clog2(MAX_WIDTH + 1);
   localparam int YW         = $clog2(MAX_HEIGHT + 1);
   localparam int PROD_W     = XW + YW;

   localparam int COLOR_W    = 16;
   localparam int COORD_W    = 16;
   localparam int DIM_W      = 9;
   localparam int CMD_W      = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PLOT        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FILL        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_IMAGE_BEGIN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_IMAGE_PIXEL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd5;

   localparam logic [1:0] REG_DRAW_ENABLE = 2'd0;
   localparam logic [1:0] REG_FB_WIDTH    = 2'd1;
   localparam logic [1:0] REG_FB_HEIGHT   = 2'd2;

   typedef struct packed {
      logic          draw_enable;
      logic [XW-1:0] width;
      logic [YW-1:0] height;
   } view_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [COLOR_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
      logic               hit;
   } result_type;

   function automatic logic [ADDR_W-1:0] pixel_addr(input logic [YW-1:0] y,
                                                    input logic [XW-1:0] x,
                                                    input logic [XW-1:0] w);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(y) * PROD_W'(w);
      return ADDR_W'(prod + PROD_W'(x));
   endfunction

endpackage

`default_nettype wire

// ===== src/crfb_fb_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module crfb_fb_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/crfb_engine.sv =====
// Command sequencer: clipping, image cursor, and the clear/fill pixel sweep.
// Drives the framebuffer RAM ports and produces one result per command.
// Depends on crfb_pkg.
`default_nettype none

module crfb_engine
   import crfb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  view_type                  view,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_type,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_size_w,
   input  logic signed [COORD_W-1:0] req_size_h,
   input  logic [COLOR_W-1:0]        req_color,
   input  logic                      out_free,
   output mem_req_type               mem,
   input  logic [COLOR_W-1:0]        rd_data,
   output result_type                result
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0]         state_ff, state_in;

   logic [COORD_W-1:0] org_x_ff, org_x_in;
   logic [COORD_W-1:0] org_y_ff, org_y_in;
   logic [COORD_W-1:0] img_w_ff, img_w_in;
   logic [COORD_W-1:0] img_h_ff, img_h_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               img_act_ff, img_act_in;

   logic [XW-1:0]      x_lo_ff, x_lo_in;
   logic [XW-1:0]      x_hi_ff, x_hi_in;
   logic [YW-1:0]      y_hi_ff, y_hi_in;
   logic [XW-1:0]      cx_ff, cx_in;
   logic [YW-1:0]      cy_ff, cy_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   logic               accept;
   logic [COORD_W:0]   dx, dy, pt_x, pt_y;
   logic               pt_hit;
   logic [ADDR_W-1:0]  pt_addr;

   logic signed [COORD_W:0] x_end, y_end, w_s, h_s;
   logic signed [COORD_W:0] fx_lo, fx_hi, fy_lo, fy_hi;
   logic               fill_ok;

   logic [XW-1:0]      s_x_lo, s_x_hi;
   logic [YW-1:0]      s_y_lo, s_y_hi;
   logic [ADDR_W-1:0]  s_base;

   logic [XW-1:0]      cx_next;
   logic [YW-1:0]      cy_next;
   logic [COORD_W-1:0] col_next, row_next;

   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign dx   = {org_x_ff[COORD_W-1], org_x_ff} + {1'b0, col_ff};
   assign dy   = {org_y_ff[COORD_W-1], org_y_ff} + {1'b0, row_ff};
   assign pt_x = (req_type == CMD_IMAGE_PIXEL) ? dx : {req_pos_x[COORD_W-1], req_pos_x};
   assign pt_y = (req_type == CMD_IMAGE_PIXEL) ? dy : {req_pos_y[COORD_W-1], req_pos_y};

   assign pt_hit = view.draw_enable
                && !pt_x[COORD_W] && (pt_x < (COORD_W+1)'(view.width))
                && !pt_y[COORD_W] && (pt_y < (COORD_W+1)'(view.height));
   assign pt_addr = pixel_addr(YW'(pt_y), XW'(pt_x), view.width);

   assign w_s   = $signed({1'b0, COORD_W'(view.width)});
   assign h_s   = $signed({1'b0, COORD_W'(view.height)});
   assign x_end = $signed({req_pos_x[COORD_W-1], req_pos_x})
                + $signed({req_size_w[COORD_W-1], req_size_w});
   assign y_end = $signed({req_pos_y[COORD_W-1], req_pos_y})
                + $signed({req_size_h[COORD_W-1], req_size_h});
   assign fx_lo = req_pos_x[COORD_W-1] ? '0 : $signed({1'b0, req_pos_x});
   assign fy_lo = req_pos_y[COORD_W-1] ? '0 : $signed({1'b0, req_pos_y});
   assign fx_hi = (x_end < w_s) ? x_end : w_s;
   assign fy_hi = (y_end < h_s) ? y_end : h_s;
   assign fill_ok = !req_size_w[COORD_W-1] && (req_size_w != '0)
                 && !req_size_h[COORD_W-1] && (req_size_h != '0)
                 && (fx_hi > fx_lo) && (fy_hi > fy_lo);

   always_comb begin
      if (req_type == CMD_CLEAR) begin
         s_x_lo = '0;
         s_x_hi = view.width;
         s_y_lo = '0;
         s_y_hi = view.height;
      end else begin
         s_x_lo = XW'(fx_lo);
         s_x_hi = XW'(fx_hi);
         s_y_lo = YW'(fy_lo);
         s_y_hi = YW'(fy_hi);
      end
   end

   assign s_base   = pixel_addr(s_y_lo, '0, view.width);
   assign cx_next  = cx_ff + XW'(1);
   assign cy_next  = cy_ff + YW'(1);
   assign col_next = col_ff + COORD_W'(1);
   assign row_next = row_ff + COORD_W'(1);

   always_comb begin
      state_in   = state_ff;
      org_x_in   = org_x_ff;
      org_y_in   = org_y_ff;
      img_w_in   = img_w_ff;
      img_h_in   = img_h_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      img_act_in = img_act_ff;
      x_lo_in    = x_lo_ff;
      x_hi_in    = x_hi_ff;
      y_hi_in    = y_hi_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      addr_in    = addr_ff;
      base_in    = base_ff;
      color_in   = color_ff;
      mem        = '0;
      result     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type) inside
                  CMD_CLEAR, CMD_FILL: begin
                     if (view.draw_enable && ((req_type == CMD_CLEAR)
                         ? (view.width != '0 && view.height != '0) : fill_ok)) begin
                        x_lo_in  = s_x_lo;
                        x_hi_in  = s_x_hi;
                        y_hi_in  = s_y_hi;
                        cx_in    = s_x_lo;
                        cy_in    = s_y_lo;
                        base_in  = s_base;
                        addr_in  = s_base + ADDR_W'(s_x_lo);
                        color_in = req_color;
                        state_in = ST_SWEEP;
                     end else begin
                        result.valid = 1'b1;
                     end
                  end
                  CMD_PLOT: begin
                     mem.wr_en    = pt_hit;
                     mem.wr_addr  = pt_addr;
                     mem.wr_data  = req_color;
                     result.valid = 1'b1;
                     result.hit   = pt_hit;
                  end
                  CMD_IMAGE_BEGIN: begin
                     org_x_in     = req_pos_x;
                     org_y_in     = req_pos_y;
                     img_w_in     = req_size_w;
                     img_h_in     = req_size_h;
                     col_in       = '0;
                     row_in       = '0;
                     img_act_in   = !req_size_w[COORD_W-1] && (req_size_w != '0)
                                 && !req_size_h[COORD_W-1] && (req_size_h != '0);
                     result.valid = 1'b1;
                  end
                  CMD_IMAGE_PIXEL: begin
                     result.valid = 1'b1;
                     if (img_act_ff) begin
                        mem.wr_en   = pt_hit;
                        mem.wr_addr = pt_addr;
                        mem.wr_data = req_color;
                        result.hit  = pt_hit;
                        if (col_next >= img_w_ff) begin
                           col_in = '0;
                           row_in = row_next;
                           if (row_next >= img_h_ff) begin
                              img_act_in = 1'b0;
                           end
                        end else begin
                           col_in = col_next;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (pt_hit) begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = pt_addr;
                        state_in    = ST_READ;
                     end else begin
                        result.valid = 1'b1;
                     end
                  end
                  default: begin
                     result.valid = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = addr_ff;
            mem.wr_data = color_ff;
            if (cx_next == x_hi_ff) begin
               if (cy_next == y_hi_ff) begin
                  result.valid = 1'b1;
                  result.hit   = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cy_in   = cy_next;
                  cx_in   = x_lo_ff;
                  base_in = base_ff + ADDR_W'(view.width);
                  addr_in = base_ff + ADDR_W'(view.width) + ADDR_W'(x_lo_ff);
               end
            end else begin
               cx_in   = cx_next;
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ST_READ: begin
            result.valid = 1'b1;
            result.color = rd_data;
            result.hit   = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         img_act_ff <= 1'b0;
         org_x_ff   <= '0;
         org_y_ff   <= '0;
         img_w_ff   <= '0;
         img_h_ff   <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         img_act_ff <= img_act_in;
         org_x_ff   <= org_x_in;
         org_y_ff   <= org_y_in;
         img_w_ff   <= img_w_in;
         img_h_ff   <= img_h_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      x_lo_ff  <= x_lo_in;
      x_hi_ff  <= x_hi_in;
      y_hi_ff  <= y_hi_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      addr_ff  <= addr_in;
      base_ff  <= base_in;
      color_ff <= color_in;
   end

endmodule

`default_nettype wire

// ===== src/clipped_raster_fill_and_blit.sv =====
// Plot, image and miss commands give their registered result in the cycle after
// transfer; a read that hits the screen passes the RAM read register first.
// Clear and fill write one pixel per cycle through the single RAM write port:
// the result comes with the last write. Input is held for sweeps and read hits.
// Throughput: one plot, image or miss command per cycle unless a result is stalled.
// Reset: synchronous; control state clears at once, pixel store is not cleared.
`default_nettype none

module clipped_raster_fill_and_blit
   import crfb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_type,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_size_w,
   input  logic signed [COORD_W-1:0] req_size_h,
   input  logic [COLOR_W-1:0]        req_color,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COLOR_W-1:0]        rsp_read_color,
   output logic                      rsp_in_bounds
);

   logic               draw_enable_ff;
   logic [DIM_W-1:0]   fb_width_ff;
   logic [DIM_W-1:0]   fb_height_ff;
   logic               csr_wr;
   view_type           view;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic               rsp_hit_ff;
   logic               out_free;

   mem_req_type        mem;
   result_type         result;
   logic [COLOR_W-1:0] rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_enable_ff <= 1'b0;
         fb_width_ff    <= '0;
         fb_height_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_DRAW_ENABLE: draw_enable_ff <= csr_pwdata[0];
            REG_FB_WIDTH:    fb_width_ff    <= csr_pwdata[DIM_W-1:0];
            REG_FB_HEIGHT:   fb_height_ff   <= csr_pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DRAW_ENABLE: csr_prdata = CSR_DATA_W'(draw_enable_ff);
         REG_FB_WIDTH:    csr_prdata = CSR_DATA_W'(fb_width_ff);
         REG_FB_HEIGHT:   csr_prdata = CSR_DATA_W'(fb_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign view.draw_enable = draw_enable_ff;
   assign view.width  = (32'(fb_width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(fb_width_ff);
   assign view.height = (32'(fb_height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT)
                                                          : YW'(fb_height_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   crfb_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .view       (view),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_size_w (req_size_w),
      .req_size_h (req_size_h),
      .req_color  (req_color),
      .out_free   (out_free),
      .mem        (mem),
      .rd_data    (rd_data),
      .result     (result)
   );

   crfb_fb_ram #(
      .DATA_W (COLOR_W),
      .DEPTH  (FB_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_fb_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_color_ff <= result.color;
         rsp_hit_ff   <= result.hit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;
   assign rsp_in_bounds  = rsp_hit_ff;

endmodule

`default_nettype wire

// ===== src/crfb_checker.sv =====
// Port-level checker for the raster engine, bound to the top level.
// Depends on crfb_pkg and on clipped_raster_fill_and_blit.
`default_nettype none

module crfb_checker
   import crfb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [CMD_W-1:0]     req_type,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [COLOR_W-1:0]   rsp_read_color,
   input logic                 rsp_in_bounds
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_color)
                                 && $stable(rsp_in_bounds))
      else $error("result changed while stalled");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("command taken while result register full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_bounds |-> rsp_read_color == '0)
      else $error("nonzero color on out-of-bounds result");

   a_plot_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == CMD_PLOT) |=> rsp_valid)
      else $error("plot result not presented next cycle");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind clipped_raster_fill_and_blit crfb_checker u_crfb_checker (.*);

`default_nettype wire

// ===== bench/tb_clipped_raster_fill_and_blit.sv =====
// Testbench for clipped_raster_fill_and_blit: directed and random command streams,
// each result checked against a shadow framebuffer and clip state kept in the bench.
// Depends on crfb_pkg and the block under test only.
`timescale 1ns / 1ps

module tb_clipped_raster_fill_and_blit
   import crfb_pkg::*;
();

   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
   localparam int IDLE_LIMIT    = 300000;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 120;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               hit;
   } pixel_reply_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_type    = '0;
   logic signed [COORD_W-1:0] req_pos_x   = '0;
   logic signed [COORD_W-1:0] req_pos_y   = '0;
   logic signed [COORD_W-1:0] req_size_w  = '0;
   logic signed [COORD_W-1:0] req_size_h  = '0;
   logic [COLOR_W-1:0]        req_color   = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic [COLOR_W-1:0]        rsp_read_color;
   logic                      rsp_in_bounds;

   bit                        steady = 1'b0;
   int                        fault_count = 0;
   int                        idle_cycles = 0;
   pixel_reply_type           cmd_results_q[$];
   pixel_reply_type           want;

   bit                        draw_on = 1'b0;
   logic [DIM_W-1:0]          fb_w_reg = '0;
   logic [DIM_W-1:0]          fb_h_reg = '0;
   int                        img_x, img_y, img_w, img_h, img_col, img_row;
   bit                        img_on = 1'b0;
   logic [COLOR_W-1:0]        fb_shadow [0:FB_DEPTH-1];
   bit                        fb_written [0:FB_DEPTH-1];

   clipped_raster_fill_and_blit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_size_w     (req_size_w),
      .req_size_h     (req_size_h),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_color (rsp_read_color),
      .rsp_in_bounds  (rsp_in_bounds)
   );

   always #1 clock = ~clock;

   function automatic int view_w();
      return (fb_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(fb_w_reg);
   endfunction

   function automatic int view_h();
      return (fb_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(fb_h_reg);
   endfunction

   function automatic bit on_screen(input int x, input int y);
      return x >= 0 && x < view_w() && y >= 0 && y < view_h();
   endfunction

   function automatic int pixel_index(input int x, input int y);
      return (y * view_w() + x) % FB_DEPTH;
   endfunction

   function automatic int near(input int lim);
      return int'($urandom_range(lim + 4)) - 2;
   endfunction

   task automatic shadow_draw(input logic [CMD_W-1:0] kind, input int px, input int py,
                              input int sw, input int sh, input logic [COLOR_W-1:0] col,
                              output pixel_reply_type reply);
      int w, h, x0, x1, y0, y1, xx, yy, i, dx, dy;
      w = view_w();
      h = view_h();
      reply = '0;
      case (kind)
         CMD_CLEAR: begin
            if (draw_on && w > 0 && h > 0) begin
               for (i = 0; i < w * h; i++) begin
                  fb_shadow[i] = col;
                  fb_written[i] = 1'b1;
               end
               reply.hit = 1'b1;
            end
         end
         CMD_PLOT: begin
            if (draw_on && on_screen(px, py)) begin
               fb_shadow[pixel_index(px, py)] = col;
               fb_written[pixel_index(px, py)] = 1'b1;
               reply.hit = 1'b1;
            end
         end
         CMD_FILL: begin
            if (draw_on && sw > 0 && sh > 0) begin
               x0 = (px < 0) ? 0 : px;
               y0 = (py < 0) ? 0 : py;
               x1 = (px + sw < w) ? px + sw : w;
               y1 = (py + sh < h) ? py + sh : h;
               for (yy = y0; yy < y1; yy++)
                  for (xx = x0; xx < x1; xx++) begin
                     fb_shadow[pixel_index(xx, yy)] = col;
                     fb_written[pixel_index(xx, yy)] = 1'b1;
                     reply.hit = 1'b1;
                  end
            end
         end
         CMD_IMAGE_BEGIN: begin
            img_x = px;
            img_y = py;
            img_w = sw;
            img_h = sh;
            img_col = 0;
            img_row = 0;
            img_on = (sw > 0 && sh > 0);
         end
         CMD_IMAGE_PIXEL: begin
            if (img_on) begin
               dx = img_x + img_col;
               dy = img_y + img_row;
               if (draw_on && on_screen(dx, dy)) begin
                  fb_shadow[pixel_index(dx, dy)] = col;
                  fb_written[pixel_index(dx, dy)] = 1'b1;
                  reply.hit = 1'b1;
               end
               img_col++;
               if (img_col >= img_w) begin
                  img_col = 0;
                  img_row++;
                  if (img_row >= img_h)
                     img_on = 1'b0;
               end
            end
         end
         CMD_READ: begin
            if (draw_on && on_screen(px, py)) begin
               reply.color = fb_shadow[pixel_index(px, py)];
               reply.hit = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic csr_write(input logic [1:0] idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_DRAW_ENABLE: draw_on = value[0];
         REG_FB_WIDTH:    fb_w_reg = value[DIM_W-1:0];
         REG_FB_HEIGHT:   fb_h_reg = value[DIM_W-1:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_cmd(input logic [CMD_W-1:0] kind, input int px, input int py,
                           input int sw, input int sh, input int col);
      pixel_reply_type reply;
      logic signed [COORD_W-1:0] x16, y16, w16, h16;
      x16 = COORD_W'(px);
      y16 = COORD_W'(py);
      w16 = COORD_W'(sw);
      h16 = COORD_W'(sh);
      // steer reads away from entries that were never written
      if (kind == CMD_READ && draw_on && on_screen(x16, y16)
          && !fb_written[pixel_index(x16, y16)])
         x16 = -16'sd1;
      if (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_pos_x  <= x16;
      req_pos_y  <= y16;
      req_size_w <= w16;
      req_size_h <= h16;
      req_color  <= COLOR_W'(col);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow_draw(kind, x16, y16, w16, h16, COLOR_W'(col), reply);
      cmd_results_q.push_back(reply);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (cmd_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_disabled_draw();
      csr_write(REG_FB_WIDTH, 16);
      csr_write(REG_FB_HEIGHT, 8);
      send_cmd(CMD_CLEAR, 0, 0, 0, 0, 16'hFFFF);
      send_cmd(CMD_PLOT, 5, 5, 0, 0, 16'h1234);
      send_cmd(CMD_FILL, 0, 0, 4, 4, 16'h5678);
      send_cmd(CMD_READ, 5, 5, 0, 0, 0);
      send_cmd(CMD_IMAGE_BEGIN, 0, 0, 2, 1, 0);
      send_cmd(CMD_IMAGE_PIXEL, 0, 0, 0, 0, 16'hAAAA);
      settle();
      csr_write(REG_DRAW_ENABLE, 1);
      send_cmd(CMD_IMAGE_PIXEL, 0, 0, 0, 0, 16'h5555);
      send_cmd(CMD_IMAGE_PIXEL, 0, 0, 0, 0, 16'h0F0F);
      send_cmd(CMD_READ, 1, 0, 0, 0, 0);
   endtask

   task automatic check_clear_plot_read();
      send_cmd(CMD_CLEAR, 0, 0, 0, 0, 16'h0000);
      send_cmd(CMD_PLOT, 15, 7, 0, 0, 16'hFFFF);
      send_cmd(CMD_PLOT, -1, 0, 0, 0, 16'h8001);
      send_cmd(CMD_PLOT, 32767, -32768, 0, 0, 16'h7FFE);
      send_cmd(CMD_READ, 15, 7, 0, 0, 0);
      send_cmd(CMD_READ, -32768, 32767, 0, 0, 0);
   endtask

   task automatic check_fill_clipping();
      send_cmd(CMD_FILL, 2, 2, 0, 5, 16'h1111);
      send_cmd(CMD_FILL, 2, 2, 5, -1, 16'h2222);
      send_cmd(CMD_FILL, -32768, -32768, 32767, 32767, 16'h3333);
      send_cmd(CMD_FILL, 10, 4, 32767, 32767, 16'h4444);
      send_cmd(CMD_READ, 15, 7, 0, 0, 0);
   endtask

   task automatic check_image_stream();
      send_cmd(CMD_IMAGE_BEGIN, 15, 7, 2, 2, 0);
      repeat (5) send_cmd(CMD_IMAGE_PIXEL, 0, 0, 0, 0, int'($urandom));
      send_cmd(CMD_READ, 15, 7, 0, 0, 0);
      send_cmd(CMD_IMAGE_BEGIN, 0, 0, 0, 4, 0);
      send_cmd(CMD_IMAGE_PIXEL, 0, 0, 0, 0, 16'hBEEF);
      send_cmd(CMD_SPARE_6, 1, 1, 1, 1, 16'hFFFF);
      send_cmd(CMD_SPARE_7, 1, 1, 1, 1, 16'hFFFF);
   endtask

   task automatic check_screen_extremes();
      settle();
      csr_write(REG_FB_WIDTH, MAX_WIDTH);
      csr_write(REG_FB_HEIGHT, MAX_HEIGHT);
      send_cmd(CMD_CLEAR, 0, 0, 0, 0, 16'hC3C3);
      send_cmd(CMD_READ, MAX_WIDTH - 1, MAX_HEIGHT - 1, 0, 0, 0);
      settle();
      csr_write(REG_FB_WIDTH, 0);
      send_cmd(CMD_CLEAR, 0, 0, 0, 0, 16'h3C3C);
   endtask

   task automatic run_random_phase(input int phase_no);
      int w_pick, h_pick, en_pick, done, r, iw, ih, count, k, fill_cap;
      logic [CMD_W-1:0] kind;
      int sw, sh;
      case (phase_no)
         0: begin w_pick = MAX_WIDTH; h_pick = MAX_HEIGHT; en_pick = 1; end
         1: begin w_pick = 1; h_pick = 1; en_pick = 1; end
         2: begin w_pick = 0; h_pick = 10; en_pick = 1; end
         3: begin w_pick = MAX_WIDTH; h_pick = 3; en_pick = 1; end
         4: begin w_pick = 5; h_pick = MAX_HEIGHT; en_pick = 1; end
         5: begin w_pick = 20; h_pick = 20; en_pick = 0; end
         default: begin
            w_pick = $urandom_range(1, 40);
            h_pick = $urandom_range(1, 40);
            en_pick = ($urandom_range(9) != 0);
         end
      endcase
      settle();
      steady = (phase_no == 7);
      csr_write(REG_DRAW_ENABLE, en_pick);
      csr_write(REG_FB_WIDTH, w_pick);
      csr_write(REG_FB_HEIGHT, h_pick);
      send_cmd(CMD_CLEAR, 0, 0, 0, 0, int'($urandom));
      fill_cap = (w_pick * h_pick > 4096) ? 48 : 300;
      done = 1;
      while (done < PHASE_ITEMS) begin
         r = $urandom_range(99);
         if (r < 30) begin
            iw = $urandom_range(1, 6);
            ih = $urandom_range(1, 6);
            send_cmd(CMD_IMAGE_BEGIN, near(w_pick) - 2, near(h_pick) - 2, iw, ih,
                     int'($urandom));
            count = iw * ih;
            if ($urandom_range(99) < 15)
               count = $urandom_range(iw * ih + 3);
            for (k = 0; k < count; k++)
               send_cmd(CMD_IMAGE_PIXEL, int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom));
            done += count + 1;
         end else if (r < 45) begin
            send_cmd(CMD_PLOT, near(w_pick), near(h_pick), 0, 0, int'($urandom));
            done++;
         end else if (r < 60) begin
            sw = int'($urandom_range(((w_pick < fill_cap) ? w_pick : fill_cap) + 6)) - 3;
            sh = int'($urandom_range(((h_pick < fill_cap) ? h_pick : fill_cap) + 6)) - 3;
            send_cmd(CMD_FILL, near(w_pick) - 3, near(h_pick) - 3, sw, sh, int'($urandom));
            done++;
         end else if (r < 80 || (r < 84 && w_pick * h_pick > 2048)) begin
            send_cmd(CMD_READ, near(w_pick), near(h_pick), 0, 0, 0);
            done++;
         end else if (r < 84) begin
            send_cmd(CMD_CLEAR, int'($urandom), int'($urandom), 0, 0, int'($urandom));
            done++;
         end else if (r < 95) begin
            kind = CMD_W'($urandom_range(7));
            sw = int'($urandom);
            sh = int'($urandom);
            if (kind == CMD_CLEAR && w_pick * h_pick > 2048)
               kind = CMD_READ;
            if (kind == CMD_FILL && w_pick * h_pick > 4096) begin
               sw = sw & 63;
               sh = sh & 63;
            end
            send_cmd(kind, int'($urandom), int'($urandom), sw, sh, int'($urandom));
            done++;
         end else begin
            send_cmd(CMD_IMAGE_PIXEL, 0, 0, 0, 0, int'($urandom));
            done++;
         end
      end
   endtask

   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 8);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cmd_results_q.size() == 0) begin
            if (fault_count < MAX_REPORTS)
               $display("unexpected transfer: color %h in_bounds %b",
                        rsp_read_color, rsp_in_bounds);
            fault_count++;
         end else begin
            want = cmd_results_q.pop_front();
            if (rsp_read_color !== want.color || rsp_in_bounds !== want.hit) begin
               if (fault_count < MAX_REPORTS)
                  $display("mismatch: expected color %h in_bounds %b, got color %h in_bounds %b",
                           want.color, want.hit, rsp_read_color, rsp_in_bounds);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("tb_clipped_raster_fill_and_blit: done, errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_disabled_draw();
      check_clear_plot_read();
      check_fill_clipping();
      check_image_stream();
      check_screen_extremes();
      for (int p = 0; p < RANDOM_PHASES; p++)
         run_random_phase(p);
      settle();
      repeat (16) @(posedge clock);
      if (fault_count == 0)
         $display("tb_clipped_raster_fill_and_blit: done, clean");
      else
         $display("tb_clipped_raster_fill_and_blit: done, errors");
      $finish;
   end

endmodule
